FILE: hdl/olhtd_pkg.sv
// ----------------------------------------------------------------------------
// olhtd_pkg
// Shared types and constants for the ordered list block: request and
// result beats, request kinds and the per-cell command word.
// ----------------------------------------------------------------------------
package olhtd_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;
    localparam int KIND_W  = 2;

    // Request kinds as carried in req_type
    typedef enum logic [KIND_W-1:0] {
        REQ_FRONT  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NOP    = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [KIND_W-1:0]         req_type;
        logic signed [VALUE_W-1:0] data_value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] entry_value;
        logic                      last_entry;
        logic                      list_empty;
        logic                      overflow;
    } rsp_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_FRONT  = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_ROTATE = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        cmd;
        logic [POS_W-1:0] pos;
    } cell_ctrl_t;

endpackage

FILE: hdl/olhtd_cell.sv
// ----------------------------------------------------------------------------
// olhtd_cell
// One storage cell of the list chain. Holds one entry and, on command,
// takes the value of its left or right neighbor, the new data word, or
// the head of the list when the chain rotates.
// ----------------------------------------------------------------------------
module olhtd_cell
    import olhtd_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 6
)
(
    input  logic                      clk,
    input  cell_ctrl_t                ctrl,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic signed [VALUE_W-1:0] right_value,
    input  logic signed [VALUE_W-1:0] head_value,
    input  logic signed [VALUE_W-1:0] data_value,
    output logic signed [VALUE_W-1:0] value
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:
            begin
                value_next = value_reg;
            end
            CMD_FRONT:
            begin
                // Shift right; cell 0 sees the new word on its left input
                value_next = left_value;
            end
            CMD_APPEND:
            begin
                if (INDEX == int'(count))
                begin
                    value_next = data_value;
                end
            end
            CMD_DELETE:
            begin
                if (INDEX >= int'(ctrl.pos))
                begin
                    value_next = right_value;
                end
            end
            CMD_ROTATE:
            begin
                // Close the ring at the last occupied cell
                if (INDEX == int'(count) - 1)
                begin
                    value_next = head_value;
                end
                else
                begin
                    value_next = right_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: hdl/ordered_list_head_tail_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_head_tail_delete
// Bounded ordered list of signed 32-bit words kept in a chain of cells,
// with insert at front, append at back and delete at position.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req): one beat per request.
//   req.req_type picks insert at front, append at back, delete at
//   req.position, or no-op. A beat is taken when req_valid is high and
//   req_stall is low.
//   Result channel (rsp_valid / rsp_stall / rsp): after each request the
//   whole list goes out front to back, one beat per entry, last_entry set
//   on the final beat. An empty list gives one beat with list_empty set.
//   overflow is set on every beat of a request whose insert found the
//   list full (the list is left unchanged). A delete at a position not
//   below the current count changes nothing.
//   A taken request updates the cells and the state register; the first
//   result beat then loads into the output register. The list leaves via
//   cell 0 as the chain rotates one cell per cycle unless the result side
//   stalls, which holds the output register and freezes the rotation;
//   nothing is lost. The block returns to idle with the last beat and
//   then takes the next request. Reset empties the list (count to zero);
//   the cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module ordered_list_head_tail_delete
    import olhtd_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] emit_idx_reg;
    logic [CNT_W-1:0] emit_idx_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    cell_ctrl_t       ctrl;
    logic             accept;
    logic             load;
    logic             full;
    logic             is_last;
    logic [CNT_W-1:0] one;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];

    assign one       = {{(CNT_W-1){1'b0}}, 1'b1};
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && (state_reg == ST_IDLE);
    // Output register is free when empty or being drained this cycle
    assign load      = (state_reg == ST_EMIT) && (!rsp_valid_reg || !rsp_stall);
    assign is_last   = (count_reg == '0) || (emit_idx_reg == count_reg - one);

    // Decode the request, update the count and sequence the emission
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        emit_idx_next = emit_idx_reg;
        ovf_next      = ovf_reg;
        ctrl.cmd      = CMD_HOLD;
        ctrl.pos      = req.position;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ovf_next      = 1'b0;
                    emit_idx_next = '0;
                    state_next    = ST_EMIT;
                    case (req.req_type)
                        REQ_FRONT, REQ_APPEND:
                        begin
                            if (full)
                            begin
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.cmd   = (req.req_type == REQ_FRONT) ?
                                             CMD_FRONT : CMD_APPEND;
                                count_next = count_reg + one;
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (int'(req.position) < int'(count_reg))
                            begin
                                ctrl.cmd   = CMD_DELETE;
                                count_next = count_reg - one;
                            end
                        end
                        default:
                        begin
                            ctrl.cmd = CMD_HOLD;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    // Advance the ring by one cell per emitted beat
                    if (count_reg != '0)
                    begin
                        ctrl.cmd = CMD_ROTATE;
                    end
                    emit_idx_next = emit_idx_reg + one;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: load a fresh beat or hold while stalled
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (load)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.entry_value = (count_reg == '0) ? '0 : cell_value[0];
            rsp_next.last_entry  = is_last;
            rsp_next.list_empty  = (count_reg == '0);
            rsp_next.overflow    = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            emit_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            emit_idx_reg  <= emit_idx_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Chain of cells; cell 0 takes the new word from its left side
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = req.data_value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_mid_r
            assign right_in = cell_value[i+1];
        end

        olhtd_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .left_value  (left_in),
            .right_value (right_in),
            .head_value  (cell_value[0]),
            .data_value  (req.data_value),
            .value       (cell_value[i])
        );
    end

endmodule

FILE: tb/olhtd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olhtd_checker
// Passive monitor for the ordered list block: it mirrors the list on every
// request beat it sees taken, builds the result beats that request must
// produce and matches each result beat taken against the oldest one.
// ----------------------------------------------------------------------------
module olhtd_checker
    import olhtd_pkg::*;
#(
    parameter int CAPACITY = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   error_count,
    output int   pending_beats,
    output int   beats_checked,
    output int   overflow_reqs
);

    logic signed [VALUE_W-1:0] list_words[$];
    rsp_t                      expected_beats[$];
    int                        errs     = 0;
    int                        checked  = 0;
    int                        ovf_seen = 0;

    // Update the mirrored list and queue the full list dump it causes
    task automatic apply_request(input req_t r);
        logic ovf;
        rsp_t beat;
        int   i;
        ovf = 1'b0;
        case (req_kind_t'(r.req_type))
            REQ_FRONT:
                if (list_words.size() >= CAPACITY)
                    ovf = 1'b1;
                else
                    list_words.push_front(r.data_value);
            REQ_APPEND:
                if (list_words.size() >= CAPACITY)
                    ovf = 1'b1;
                else
                    list_words.push_back(r.data_value);
            REQ_DELETE:
                if (int'(r.position) < list_words.size())
                    list_words.delete(int'(r.position));
            default: ;
        endcase
        if (ovf)
            ovf_seen++;
        if (list_words.size() == 0)
        begin
            beat.entry_value = '0;
            beat.last_entry  = 1'b1;
            beat.list_empty  = 1'b1;
            beat.overflow    = ovf;
            expected_beats.push_back(beat);
        end
        else
        begin
            for (i = 0; i < list_words.size(); i++)
            begin
                beat.entry_value = list_words[i];
                beat.last_entry  = (i == list_words.size() - 1);
                beat.list_empty  = 1'b0;
                beat.overflow    = ovf;
                expected_beats.push_back(beat);
            end
        end
    endtask

    task automatic check_beat(input rsp_t got);
        rsp_t want;
        if (expected_beats.size() == 0)
        begin
            errs++;
            $display("%0t ERROR: unexpected result beat, expected none, got %p",
                     $time, got);
        end
        else
        begin
            want = expected_beats.pop_front();
            checked++;
            // entry_value is a don't care on an empty-list beat
            if (!want.list_empty && got.entry_value !== want.entry_value)
            begin
                errs++;
                $display("%0t ERROR: entry_value expected %0d got %0d",
                         $time, want.entry_value, got.entry_value);
            end
            if (got.last_entry !== want.last_entry)
            begin
                errs++;
                $display("%0t ERROR: last_entry expected %b got %b",
                         $time, want.last_entry, got.last_entry);
            end
            if (got.list_empty !== want.list_empty)
            begin
                errs++;
                $display("%0t ERROR: list_empty expected %b got %b",
                         $time, want.list_empty, got.list_empty);
            end
            if (got.overflow !== want.overflow)
            begin
                errs++;
                $display("%0t ERROR: overflow expected %b got %b",
                         $time, want.overflow, got.overflow);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_words.delete();
            expected_beats.delete();
            error_count   <= 0;
            pending_beats <= 0;
            beats_checked <= 0;
            overflow_reqs <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_beat(rsp);
            if (req_valid && !req_stall)
                apply_request(req);
            error_count   <= errs;
            pending_beats <= expected_beats.size();
            beats_checked <= checked;
            overflow_reqs <= ovf_seen;
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the ordered list block. A short directed run
// covers empty-list requests, extreme values and deletes at the edges and
// out of range; random phases then fill the list past capacity, churn it
// and drain it, with random idling on both channels. The checker beside
// the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
    import olhtd_pkg::*;

    localparam int LIST_CAP = 32;

    // Phases of the random part
    localparam int PH_FILL  = 0;
    localparam int PH_MIXED = 1;
    localparam int PH_DRAIN = 2;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    int   error_count;
    int   pending_beats;
    int   beats_checked;
    int   overflow_reqs;

    // Mirror of the list length, only used to steer stimulus
    int   shadow_count = 0;
    int   reqs_sent    = 0;
    // When set, neither side inserts idle cycles
    bit   calm         = 1'b0;

    ordered_list_head_tail_delete #(
        .CAPACITY (LIST_CAP)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    olhtd_checker #(
        .CAPACITY (LIST_CAP)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp),
        .error_count   (error_count),
        .pending_beats (pending_beats),
        .beats_checked (beats_checked),
        .overflow_reqs (overflow_reqs)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic req_t make_req(input req_kind_t kind,
                                      input logic [VALUE_W-1:0] value,
                                      input logic [POS_W-1:0] pos);
        req_t item;
        item.req_type   = kind;
        item.data_value = value;
        item.position   = pos;
        return item;
    endfunction

    // Pick a delete position inside the current list when there is one
    function automatic logic [POS_W-1:0] live_pos();
        if (shadow_count == 0)
            return POS_W'($urandom_range(0, 31));
        return POS_W'($urandom_range(0, shadow_count - 1));
    endfunction

    // Draw one random request, weighted by phase
    function automatic req_t pick_request(input int phase);
        int        roll;
        req_kind_t kind;
        logic [POS_W-1:0] pos;
        roll = $urandom_range(0, 99);
        pos  = POS_W'($urandom_range(0, 31));
        case (phase)
            PH_FILL:
            begin
                if (roll < 85)
                    kind = roll[0] ? REQ_FRONT : REQ_APPEND;
                else if (roll < 95)
                begin
                    kind = REQ_DELETE;
                    pos  = live_pos();
                end
                else
                    kind = roll[0] ? REQ_NOP : REQ_DELETE;
            end
            PH_DRAIN:
            begin
                if (roll < 75)
                begin
                    kind = REQ_DELETE;
                    pos  = live_pos();
                end
                else if (roll < 85)
                    kind = REQ_DELETE;
                else if (roll < 95)
                    kind = roll[0] ? REQ_FRONT : REQ_APPEND;
                else
                    kind = REQ_NOP;
            end
            default:
            begin
                kind = req_kind_t'(roll[1:0]);
                if (kind == REQ_DELETE && roll > 50)
                    pos = live_pos();
            end
        endcase
        return make_req(kind, $urandom, pos);
    endfunction

    // Present one request beat and hold it until taken. With a zero gap
    // valid stays high straight into the next beat.
    task automatic send_req(input req_t item);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!req_stall)
                break;
        end
        reqs_sent++;
        case (req_kind_t'(item.req_type))
            REQ_FRONT, REQ_APPEND:
                if (shadow_count < LIST_CAP)
                    shadow_count++;
            REQ_DELETE:
                if (int'(item.position) < shadow_count)
                    shadow_count--;
            default: ;
        endcase
    endtask

    // Result side: stall for a random number of cycles, then drop stall
    // and hold it low until a beat is taken.
    initial
    begin
        int gap;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                rsp_stall <= 1'b0;
            end
            forever
            begin
                @(posedge clk);
                if (rsp_valid && !rsp_stall)
                    break;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int n;
        int phase;
        int plan_phase[4];
        int plan_len[4];
        int p;

        plan_phase = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_MIXED};
        plan_len   = '{50, 25, 45, 30};

        // Hold every input at a known value through reset
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: requests on an empty list
        send_req(make_req(REQ_NOP,    32'h0,        5'd0));
        send_req(make_req(REQ_DELETE, 32'h0,        5'd0));
        // Extreme values at both ends, plus alternating bit patterns
        send_req(make_req(REQ_FRONT,  32'h7fffffff, 5'd31));
        send_req(make_req(REQ_APPEND, 32'h80000000, 5'd0));
        send_req(make_req(REQ_FRONT,  32'h00000000, 5'd21));
        send_req(make_req(REQ_APPEND, 32'hffffffff, 5'd10));
        send_req(make_req(REQ_FRONT,  32'h55555555, 5'd31));
        send_req(make_req(REQ_APPEND, 32'haaaaaaaa, 5'd0));
        // Deletes out of range: far out and one past the tail
        send_req(make_req(REQ_DELETE, 32'hffffffff, 5'd31));
        send_req(make_req(REQ_DELETE, 32'h0,        POS_W'(shadow_count)));
        // Deletes at the head, at the tail and in the middle
        send_req(make_req(REQ_DELETE, 32'h0,        5'd0));
        send_req(make_req(REQ_DELETE, 32'h0,        POS_W'(shadow_count - 1)));
        send_req(make_req(REQ_DELETE, 32'h0,        5'd1));
        send_req(make_req(REQ_NOP,    32'hffffffff, 5'd31));
        // Drain to empty from the head
        while (shadow_count > 0)
            send_req(make_req(REQ_DELETE, $urandom, 5'd0));
        send_req(make_req(REQ_APPEND, 32'h00000001, 5'd31));
        send_req(make_req(REQ_DELETE, 32'h0,        5'd0));

        // Random: fill past capacity, churn, drain, churn. The first
        // mixed phase runs with no idling on either side.
        for (p = 0; p < 4; p++)
        begin
            phase = plan_phase[p];
            calm  = (p == 1);
            for (n = 0; n < plan_len[p]; n++)
                send_req(pick_request(phase));
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // Let the checker count the last request, then drain its results
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (2 * LIST_CAP + 8) @(posedge clk);

        $display("Summary: %0d requests sent, %0d result beats checked,",
                 reqs_sent, beats_checked);
        $display("         %0d inserts dropped on a full list", overflow_reqs);
        if (error_count == 0 && pending_beats == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: ordered_list_head_tail_delete.f
hdl/olhtd_pkg.sv
hdl/olhtd_cell.sv
hdl/ordered_list_head_tail_delete.sv
tb/olhtd_checker.sv
tb/tb.sv
